// File: design/srse_pkg.sv
// Package for the sequencing read statistics engine.
// Holds word types, table selector codes, state encoding and constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package srse_pkg;

    localparam int MAX_POS_DEF = 4096;
    localparam int KMER_SIZE   = 5;
    localparam int KMER_DEPTH  = 1024;
    localparam int HIST_DEPTH  = 128;

    localparam logic [6:0] Q20_RESET   = 7'd53;
    localparam logic [6:0] Q30_RESET   = 7'd63;
    localparam logic [6:0] QUAL_OFFSET = 7'd33;
    localparam logic [6:0] MED_NONE    = 7'd127;

    localparam logic [0:0] CFG_Q20 = 1'b0;
    localparam logic [0:0] CFG_Q30 = 1'b1;

    localparam logic [0:0] ACT_BASE = 1'b0;
    localparam logic [0:0] ACT_READ = 1'b1;

    localparam logic [0:0] KIND_MEDIAN  = 1'b0;
    localparam logic [0:0] KIND_READOUT = 1'b1;

    localparam logic [3:0] TBL_Q30      = 4'd0;
    localparam logic [3:0] TBL_Q20      = 4'd1;
    localparam logic [3:0] TBL_CONTENT  = 4'd2;
    localparam logic [3:0] TBL_QUALSUM  = 4'd3;
    localparam logic [3:0] TBL_POSTOT   = 4'd4;
    localparam logic [3:0] TBL_POSQUAL  = 4'd5;
    localparam logic [3:0] TBL_KMER     = 4'd6;
    localparam logic [3:0] TBL_BASEHIST = 4'd7;
    localparam logic [3:0] TBL_MEDHIST  = 4'd8;
    localparam logic [3:0] TBL_READS    = 4'd9;
    localparam logic [3:0] TBL_LENSUM   = 4'd10;
    localparam logic [3:0] TBL_OVERFLOW = 4'd11;

    typedef struct packed {
        logic        action;
        logic [7:0]  base_char;
        logic [6:0]  qual_char;
        logic        last_in_read;
        logic [3:0]  table_select;
        logic [14:0] read_index;
    } in_word_t;

    typedef struct packed {
        logic        result_kind;
        logic [6:0]  median_quality;
        logic [47:0] counter_value;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_CLR,
        ST_IDLE,
        ST_EXEC,
        ST_RDOUT,
        ST_WALK,
        ST_MHRD,
        ST_MHWR
    } state_t;

    // bit 2 = letter is A/C/G/T/U, bits 1:0 = 2-bit code
    function automatic logic [2:0] letter_code(input logic [7:0] c);
        logic [2:0] r;
        r = 3'b000;
        case (c)
            8'h41: r = 3'b100;
            8'h54,
            8'h55: r = 3'b101;
            8'h43: r = 3'b110;
            8'h47: r = 3'b111;
            default: r = 3'b000;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: design/srse_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// Used by sequencing_read_stats_engine; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module srse_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [0:(1<<AW)-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: design/sequencing_read_stats_engine.sv
// Sequencing read statistics engine, top level.
// Depends on srse_pkg and srse_ram.
// After reset the block steps through max(8*MAX_POS, 1024) addresses clearing
// all counter memories, with in_ready low. A base word then first reads the
// counter memories and then writes them back. The last base of a read adds a
// median walk over the 128-bin per-read histogram (one bin a cycle, clearing
// bins as it goes), then a read and a write of the median histogram. A readout
// word reads the memories, then loads its result. Results wait
// in an output register; the block stalls only when that register is full.
`timescale 1ns / 1ps
`default_nettype none

module sequencing_read_stats_engine #(
    parameter int MAX_POS = srse_pkg::MAX_POS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire srse_pkg::in_word_t  in_word,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output srse_pkg::out_word_t      out_word,
    input  wire logic                cfg_we,
    input  wire logic [0:0]          cfg_index,
    input  wire logic [6:0]          cfg_data
);

    localparam int CDEPTH = 8 * MAX_POS;
    localparam int CIW    = $clog2(CDEPTH);
    localparam int PW     = $clog2(MAX_POS);
    localparam int KW     = $clog2(srse_pkg::KMER_DEPTH);
    localparam int HW     = $clog2(srse_pkg::HIST_DEPTH);
    localparam int CLR_DEPTH = (CDEPTH > srse_pkg::KMER_DEPTH) ? CDEPTH
                                                               : srse_pkg::KMER_DEPTH;
    localparam int CLRW   = $clog2(CLR_DEPTH);
    localparam int CLSW   = 168;
    localparam int POSW   = 88;

    srse_pkg::state_t state_reg, state_next;
    logic [CLRW-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [6:0]       q20_thr_reg, q30_thr_reg;
    logic [31:0]      position_reg, position_next;
    logic [7:0]       window_reg, window_next;
    logic [2:0]       run_reg, run_next;
    logic [39:0]      read_count_reg, read_count_next;
    logic [47:0]      length_sum_reg, length_sum_next;
    logic             overflow_reg, overflow_next;
    logic [3:0]       sel_reg, sel_next;
    logic             range_ok_reg, range_ok_next;
    logic [CIW-1:0]   cls_addr_reg, cls_addr_next;
    logic [PW-1:0]    pos_addr_reg, pos_addr_next;
    logic [KW-1:0]    kmer_addr_reg, kmer_addr_next;
    logic [HW-1:0]    qh_addr_reg, qh_addr_next;
    logic [HW-1:0]    mh_addr_reg, mh_addr_next;
    logic             last_reg, last_next;
    logic             in_pos_reg, in_pos_next;
    logic             kmer_hit_reg, kmer_hit_next;
    logic [32:0]      len_reg, len_next;
    logic [7:0]       walk_cnt_reg, walk_cnt_next;
    logic [39:0]      total_reg, total_next;
    logic             found_reg, found_next;
    logic [6:0]       med_reg, med_next;
    logic             out_valid_reg, out_valid_next;
    srse_pkg::out_word_t out_word_reg, out_word_next;

    logic            cls_we, pos_we, kmer_we, qh_we, mh_we, rqh_we;
    logic [CIW-1:0]  cls_waddr, cls_raddr;
    logic [PW-1:0]   pos_waddr, pos_raddr;
    logic [KW-1:0]   kmer_waddr, kmer_raddr;
    logic [HW-1:0]   qh_waddr, qh_raddr, mh_waddr, mh_raddr, rqh_waddr, rqh_raddr;
    logic [CLSW-1:0] cls_wdata, cls_rdata;
    logic [POSW-1:0] pos_wdata, pos_rdata;
    logic [47:0]     kmer_wdata, kmer_rdata, qh_wdata, qh_rdata;
    logic [39:0]     mh_wdata, mh_rdata;
    logic [31:0]     rqh_wdata, rqh_rdata;

    srse_ram #(.DEPTH(CDEPTH), .WIDTH(CLSW)) u_cls_ram (
        .clk(clk), .we(cls_we), .waddr(cls_waddr), .wdata(cls_wdata),
        .raddr(cls_raddr), .rdata(cls_rdata));
    srse_ram #(.DEPTH(MAX_POS), .WIDTH(POSW)) u_pos_ram (
        .clk(clk), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
        .raddr(pos_raddr), .rdata(pos_rdata));
    srse_ram #(.DEPTH(srse_pkg::KMER_DEPTH), .WIDTH(48)) u_kmer_ram (
        .clk(clk), .we(kmer_we), .waddr(kmer_waddr), .wdata(kmer_wdata),
        .raddr(kmer_raddr), .rdata(kmer_rdata));
    srse_ram #(.DEPTH(srse_pkg::HIST_DEPTH), .WIDTH(48)) u_qh_ram (
        .clk(clk), .we(qh_we), .waddr(qh_waddr), .wdata(qh_wdata),
        .raddr(qh_raddr), .rdata(qh_rdata));
    srse_ram #(.DEPTH(srse_pkg::HIST_DEPTH), .WIDTH(40)) u_mh_ram (
        .clk(clk), .we(mh_we), .waddr(mh_waddr), .wdata(mh_wdata),
        .raddr(mh_raddr), .rdata(mh_rdata));
    srse_ram #(.DEPTH(srse_pkg::HIST_DEPTH), .WIDTH(32)) u_rqh_ram (
        .clk(clk), .we(rqh_we), .waddr(rqh_waddr), .wdata(rqh_wdata),
        .raddr(rqh_raddr), .rdata(rqh_rdata));

    logic        can_load;
    logic [31:0] idx32;
    logic [2:0]  lcode;
    logic [47:0] qv;
    logic [39:0] q30_c, q20_c, cnt_c, ptot_c;
    logic [47:0] qsum_c, pqs_c;
    logic [39:0] walk_sum;
    logic [47:0] rd_value;

    assign can_load = !out_valid_reg || out_ready;
    assign idx32    = {17'd0, in_word.read_index};
    assign lcode    = srse_pkg::letter_code(in_word.base_char);
    assign qv       = {41'd0, qh_addr_reg} - {41'd0, srse_pkg::QUAL_OFFSET};
    assign q30_c    = cls_rdata[39:0];
    assign q20_c    = cls_rdata[79:40];
    assign cnt_c    = cls_rdata[119:80];
    assign qsum_c   = cls_rdata[167:120];
    assign ptot_c   = pos_rdata[39:0];
    assign pqs_c    = pos_rdata[87:40];
    assign walk_sum = total_reg + {8'd0, rqh_rdata};

    always_comb
    begin
        rd_value = 48'd0;
        case (sel_reg)
            srse_pkg::TBL_Q30:      rd_value = {8'd0, q30_c};
            srse_pkg::TBL_Q20:      rd_value = {8'd0, q20_c};
            srse_pkg::TBL_CONTENT:  rd_value = {8'd0, cnt_c};
            srse_pkg::TBL_QUALSUM:  rd_value = qsum_c;
            srse_pkg::TBL_POSTOT:   rd_value = {8'd0, ptot_c};
            srse_pkg::TBL_POSQUAL:  rd_value = pqs_c;
            srse_pkg::TBL_KMER:     rd_value = kmer_rdata;
            srse_pkg::TBL_BASEHIST: rd_value = qh_rdata;
            srse_pkg::TBL_MEDHIST:  rd_value = {8'd0, mh_rdata};
            srse_pkg::TBL_READS:    rd_value = {8'd0, read_count_reg};
            srse_pkg::TBL_LENSUM:   rd_value = length_sum_reg;
            srse_pkg::TBL_OVERFLOW: rd_value = {47'd0, overflow_reg};
            default:                rd_value = 48'd0;
        endcase
        if (!range_ok_reg)
        begin
            rd_value = 48'd0;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        position_next   = position_reg;
        window_next     = window_reg;
        run_next        = run_reg;
        read_count_next = read_count_reg;
        length_sum_next = length_sum_reg;
        overflow_next   = overflow_reg;
        sel_next        = sel_reg;
        range_ok_next   = range_ok_reg;
        cls_addr_next   = cls_addr_reg;
        pos_addr_next   = pos_addr_reg;
        kmer_addr_next  = kmer_addr_reg;
        qh_addr_next    = qh_addr_reg;
        mh_addr_next    = mh_addr_reg;
        last_next       = last_reg;
        in_pos_next     = in_pos_reg;
        kmer_hit_next   = kmer_hit_reg;
        len_next        = len_reg;
        walk_cnt_next   = walk_cnt_reg;
        total_next      = total_reg;
        found_next      = found_reg;
        med_next        = med_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_word_next   = out_word_reg;
        in_ready        = 1'b0;

        cls_raddr  = cls_addr_reg;
        pos_raddr  = pos_addr_reg;
        kmer_raddr = kmer_addr_reg;
        qh_raddr   = qh_addr_reg;
        mh_raddr   = mh_addr_reg;
        rqh_raddr  = qh_addr_reg;

        cls_we = 1'b0;  cls_waddr  = cls_addr_reg;  cls_wdata  = '0;
        pos_we = 1'b0;  pos_waddr  = pos_addr_reg;  pos_wdata  = '0;
        kmer_we = 1'b0; kmer_waddr = kmer_addr_reg; kmer_wdata = '0;
        qh_we = 1'b0;   qh_waddr   = qh_addr_reg;   qh_wdata   = '0;
        mh_we = 1'b0;   mh_waddr   = med_reg;       mh_wdata   = '0;
        rqh_we = 1'b0;  rqh_waddr  = qh_addr_reg;   rqh_wdata  = '0;

        unique case (state_reg)
            srse_pkg::ST_CLR:
            begin
                cls_we = 1'b1;  cls_waddr  = clr_cnt_reg[CIW-1:0];
                pos_we = 1'b1;  pos_waddr  = clr_cnt_reg[PW-1:0];
                kmer_we = 1'b1; kmer_waddr = clr_cnt_reg[KW-1:0];
                qh_we = 1'b1;   qh_waddr   = clr_cnt_reg[HW-1:0];
                mh_we = 1'b1;   mh_waddr   = clr_cnt_reg[HW-1:0];
                rqh_we = 1'b1;  rqh_waddr  = clr_cnt_reg[HW-1:0];
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CLRW'(CLR_DEPTH - 1))
                begin
                    state_next = srse_pkg::ST_IDLE;
                end
            end

            srse_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_word.action == srse_pkg::ACT_READ)
                begin
                    cls_addr_next  = idx32[CIW-1:0];
                    pos_addr_next  = idx32[PW-1:0];
                    kmer_addr_next = idx32[KW-1:0];
                    qh_addr_next   = idx32[HW-1:0];
                    mh_addr_next   = idx32[HW-1:0];
                end
                else
                begin
                    cls_addr_next  = CIW'(in_word.base_char[2:0]) * CIW'(MAX_POS)
                                     + CIW'(position_reg[PW-1:0]);
                    pos_addr_next  = position_reg[PW-1:0];
                    kmer_addr_next = {window_reg, lcode[1:0]};
                    qh_addr_next   = in_word.qual_char;
                end
                cls_raddr  = cls_addr_next;
                pos_raddr  = pos_addr_next;
                kmer_raddr = kmer_addr_next;
                qh_raddr   = qh_addr_next;
                mh_raddr   = mh_addr_next;
                rqh_raddr  = qh_addr_next;
                if (in_valid)
                begin
                    sel_next  = in_word.table_select;
                    last_next = in_word.last_in_read;
                    case (in_word.table_select)
                        srse_pkg::TBL_Q30, srse_pkg::TBL_Q20,
                        srse_pkg::TBL_CONTENT, srse_pkg::TBL_QUALSUM:
                            range_ok_next = idx32 < 32'(CDEPTH);
                        srse_pkg::TBL_POSTOT, srse_pkg::TBL_POSQUAL:
                            range_ok_next = idx32 < 32'(MAX_POS);
                        srse_pkg::TBL_KMER:
                            range_ok_next = idx32 < 32'(srse_pkg::KMER_DEPTH);
                        srse_pkg::TBL_BASEHIST, srse_pkg::TBL_MEDHIST:
                            range_ok_next = idx32 < 32'(srse_pkg::HIST_DEPTH);
                        default:
                            range_ok_next = 1'b1;
                    endcase
                    if (in_word.action == srse_pkg::ACT_READ)
                    begin
                        state_next = srse_pkg::ST_RDOUT;
                    end
                    else
                    begin
                        in_pos_next   = position_reg < 32'(MAX_POS);
                        kmer_hit_next = lcode[2] &&
                                        (run_reg >= 3'(srse_pkg::KMER_SIZE - 1));
                        if (!lcode[2])
                        begin
                            run_next = 3'd0;
                        end
                        else
                        begin
                            window_next = kmer_addr_next[7:0];
                            if (run_reg < 3'(srse_pkg::KMER_SIZE - 1))
                            begin
                                run_next = run_reg + 3'd1;
                            end
                        end
                        state_next = srse_pkg::ST_EXEC;
                    end
                end
            end

            srse_pkg::ST_EXEC:
            begin
                cls_we    = in_pos_reg;
                cls_wdata = {qsum_c + qv, cnt_c + 40'd1,
                             q20_c + ((qh_addr_reg >= q20_thr_reg ||
                                       qh_addr_reg >= q30_thr_reg) ? 40'd1 : 40'd0),
                             q30_c + ((qh_addr_reg >= q30_thr_reg) ? 40'd1 : 40'd0)};
                pos_we    = in_pos_reg;
                pos_wdata = {pqs_c + qv, ptot_c + 40'd1};
                kmer_we   = kmer_hit_reg;
                kmer_wdata = kmer_rdata + 48'd1;
                qh_we     = 1'b1;
                qh_wdata  = qh_rdata + 48'd1;
                rqh_we    = 1'b1;
                rqh_wdata = rqh_rdata + 32'd1;
                if (!in_pos_reg)
                begin
                    overflow_next = 1'b1;
                end
                if (last_reg)
                begin
                    len_next      = {1'b0, position_reg} + 33'd1;
                    position_next = 32'd0;
                    window_next   = 8'd0;
                    run_next      = 3'd0;
                    walk_cnt_next = 8'd0;
                    total_next    = 40'd0;
                    found_next    = 1'b0;
                    med_next      = srse_pkg::MED_NONE;
                    state_next    = srse_pkg::ST_WALK;
                end
                else
                begin
                    if (position_reg != 32'hFFFF_FFFF)
                    begin
                        position_next = position_reg + 32'd1;
                    end
                    state_next = srse_pkg::ST_IDLE;
                end
            end

            srse_pkg::ST_RDOUT:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    out_word_next.result_kind    = srse_pkg::KIND_READOUT;
                    out_word_next.median_quality = 7'd0;
                    out_word_next.counter_value  = rd_value;
                    state_next = srse_pkg::ST_IDLE;
                end
            end

            srse_pkg::ST_WALK:
            begin
                rqh_raddr = walk_cnt_reg[HW-1:0];
                if (walk_cnt_reg != 8'd0)
                begin
                    rqh_we     = 1'b1;
                    rqh_waddr  = HW'(walk_cnt_reg - 8'd1);
                    rqh_wdata  = 32'd0;
                    total_next = walk_sum;
                    if (!found_reg && walk_sum > {8'd0, len_reg[32:1]})
                    begin
                        found_next = 1'b1;
                        med_next   = HW'(walk_cnt_reg - 8'd1);
                    end
                end
                walk_cnt_next = walk_cnt_reg + 8'd1;
                if (walk_cnt_reg == 8'(srse_pkg::HIST_DEPTH))
                begin
                    state_next = srse_pkg::ST_MHRD;
                end
            end

            srse_pkg::ST_MHRD:
            begin
                mh_raddr   = med_reg;
                state_next = srse_pkg::ST_MHWR;
            end

            srse_pkg::ST_MHWR:
            begin
                mh_raddr = med_reg;
                if (can_load)
                begin
                    mh_we           = 1'b1;
                    mh_wdata        = mh_rdata + 40'd1;
                    length_sum_next = length_sum_reg + {15'd0, len_reg};
                    read_count_next = read_count_reg + 40'd1;
                    out_valid_next  = 1'b1;
                    out_word_next.result_kind    = srse_pkg::KIND_MEDIAN;
                    out_word_next.median_quality = med_reg;
                    out_word_next.counter_value  = 48'd0;
                    state_next = srse_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = srse_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= srse_pkg::ST_CLR;
            clr_cnt_reg    <= '0;
            q20_thr_reg    <= srse_pkg::Q20_RESET;
            q30_thr_reg    <= srse_pkg::Q30_RESET;
            position_reg   <= 32'd0;
            window_reg     <= 8'd0;
            run_reg        <= 3'd0;
            read_count_reg <= 40'd0;
            length_sum_reg <= 48'd0;
            overflow_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            walk_cnt_reg   <= 8'd0;
            found_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            position_reg   <= position_next;
            window_reg     <= window_next;
            run_reg        <= run_next;
            read_count_reg <= read_count_next;
            length_sum_reg <= length_sum_next;
            overflow_reg   <= overflow_next;
            out_valid_reg  <= out_valid_next;
            walk_cnt_reg   <= walk_cnt_next;
            found_reg      <= found_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    srse_pkg::CFG_Q20: q20_thr_reg <= cfg_data;
                    srse_pkg::CFG_Q30: q30_thr_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg       <= sel_next;
        range_ok_reg  <= range_ok_next;
        cls_addr_reg  <= cls_addr_next;
        pos_addr_reg  <= pos_addr_next;
        kmer_addr_reg <= kmer_addr_next;
        qh_addr_reg   <= qh_addr_next;
        mh_addr_reg   <= mh_addr_next;
        last_reg      <= last_next;
        in_pos_reg    <= in_pos_next;
        kmer_hit_reg  <= kmer_hit_next;
        len_reg       <= len_next;
        total_reg     <= total_next;
        med_reg       <= med_next;
        out_word_reg  <= out_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    a_last_walks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == srse_pkg::ST_EXEC && last_reg) |=> state_reg == srse_pkg::ST_WALK)
        else $error("last base did not start median walk");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == srse_pkg::ST_WALK |-> walk_cnt_reg <= 8'(srse_pkg::HIST_DEPTH))
        else $error("median walk ran past histogram");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == srse_pkg::ST_RDOUT ||
                                  $past(state_reg) == srse_pkg::ST_MHWR))
        else $error("result word from unexpected state");

    a_clr_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == srse_pkg::ST_CLR |-> !in_ready && !out_valid_reg)
        else $error("traffic during clearing pass");

endmodule

`default_nettype wire

// File: dv/read_stats_checker.sv
// Checker for the sequencing read statistics engine: watches both channels,
// keeps its own copy of every counter table and compares each result word.
// Depends on srse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module read_stats_checker #(
    parameter int MAX_POS = srse_pkg::MAX_POS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                in_ready,
    input  wire srse_pkg::in_word_t  in_word,
    input  wire logic                out_valid,
    input  wire logic                out_ready,
    input  wire srse_pkg::out_word_t out_word,
    input  wire logic                cfg_we,
    input  wire logic [0:0]          cfg_index,
    input  wire logic [6:0]          cfg_data,
    output int                       errors,
    output int                       pending
);

    localparam int CLASS_DEPTH = 8 * MAX_POS;

    logic [6:0]  q20_thr, q30_thr;
    logic [31:0] pos;
    logic [39:0] q30_tab [CLASS_DEPTH];
    logic [39:0] q20_tab [CLASS_DEPTH];
    logic [39:0] content_tab [CLASS_DEPTH];
    logic [47:0] qualsum_tab [CLASS_DEPTH];
    logic [39:0] pos_total [MAX_POS];
    logic [47:0] pos_qual [MAX_POS];
    logic [47:0] kmer_tab [srse_pkg::KMER_DEPTH];
    logic [47:0] base_hist [srse_pkg::HIST_DEPTH];
    logic [39:0] med_hist [srse_pkg::HIST_DEPTH];
    logic [31:0] read_hist [srse_pkg::HIST_DEPTH];
    logic [7:0]  window;
    logic [2:0]  run_len;
    logic [39:0] reads;
    logic [47:0] len_sum;
    logic        ovf;
    srse_pkg::out_word_t expected_words[$];

    task automatic report(input string what, input logic [63:0] got,
                          input logic [63:0] want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        errors++;
    endtask

    function automatic logic [47:0] counter_at(input logic [3:0] sel,
                                               input logic [14:0] idx);
        case (sel)
            srse_pkg::TBL_Q30:      return idx < CLASS_DEPTH ? 48'(q30_tab[idx]) : '0;
            srse_pkg::TBL_Q20:      return idx < CLASS_DEPTH ? 48'(q20_tab[idx]) : '0;
            srse_pkg::TBL_CONTENT:  return idx < CLASS_DEPTH ? 48'(content_tab[idx]) : '0;
            srse_pkg::TBL_QUALSUM:  return idx < CLASS_DEPTH ? qualsum_tab[idx] : '0;
            srse_pkg::TBL_POSTOT:   return idx < MAX_POS ? 48'(pos_total[idx]) : '0;
            srse_pkg::TBL_POSQUAL:  return idx < MAX_POS ? pos_qual[idx] : '0;
            srse_pkg::TBL_KMER:     return idx < srse_pkg::KMER_DEPTH ? kmer_tab[idx] : '0;
            srse_pkg::TBL_BASEHIST: return idx < srse_pkg::HIST_DEPTH ? base_hist[idx] : '0;
            srse_pkg::TBL_MEDHIST:
                return idx < srse_pkg::HIST_DEPTH ? 48'(med_hist[idx]) : '0;
            srse_pkg::TBL_READS:    return 48'(reads);
            srse_pkg::TBL_LENSUM:   return len_sum;
            srse_pkg::TBL_OVERFLOW: return 48'(ovf);
            default:                return '0;
        endcase
    endfunction

    task automatic account_word(input srse_pkg::in_word_t w);
        logic [47:0] qv;
        logic [2:0]  lc;
        logic [9:0]  k;
        int          ci;
        logic [32:0] len;
        logic [32:0] half;
        logic [63:0] total;
        logic [6:0]  med;
        srse_pkg::out_word_t r;
        qv = 48'(w.qual_char) - 48'(srse_pkg::QUAL_OFFSET);
        base_hist[w.qual_char]++;
        read_hist[w.qual_char]++;
        if (pos < MAX_POS)
        begin
            ci = int'(w.base_char[2:0]) * MAX_POS + int'(pos);
            if (w.qual_char >= q30_thr)
            begin
                q30_tab[ci]++;
                q20_tab[ci]++;
            end
            else if (w.qual_char >= q20_thr)
            begin
                q20_tab[ci]++;
            end
            content_tab[ci]++;
            qualsum_tab[ci] += qv;
            pos_total[pos]++;
            pos_qual[pos] += qv;
        end
        else
        begin
            ovf = 1'b1;
        end
        lc = 3'b000;
        case (w.base_char)
            "A": lc = 3'b100;
            "T", "U": lc = 3'b101;
            "C": lc = 3'b110;
            "G": lc = 3'b111;
            default: lc = 3'b000;
        endcase
        if (!lc[2])
        begin
            run_len = '0;
        end
        else
        begin
            k = {window, lc[1:0]};
            if (run_len >= 4)
                kmer_tab[k]++;
            else
                run_len++;
            window = k[7:0];
        end
        if (!w.last_in_read)
        begin
            if (pos != '1)
                pos++;
            return;
        end
        len = 33'(pos) + 33'd1;
        half = len >> 1;
        total = '0;
        med = srse_pkg::MED_NONE;
        for (int b = 0; b < srse_pkg::HIST_DEPTH; b++)
        begin
            total += 64'(read_hist[b]);
            if (total > 64'(half))
            begin
                med = 7'(b);
                break;
            end
        end
        med_hist[med]++;
        len_sum += 48'(len);
        reads++;
        r.result_kind = srse_pkg::KIND_MEDIAN;
        r.median_quality = med;
        r.counter_value = '0;
        expected_words.push_back(r);
        foreach (read_hist[i]) read_hist[i] = '0;
        pos = '0;
        window = '0;
        run_len = '0;
    endtask

    initial
    begin
        errors = 0;
        q20_thr = srse_pkg::Q20_RESET;
        q30_thr = srse_pkg::Q30_RESET;
        pos = '0;
        foreach (q30_tab[i]) q30_tab[i] = '0;
        foreach (q20_tab[i]) q20_tab[i] = '0;
        foreach (content_tab[i]) content_tab[i] = '0;
        foreach (qualsum_tab[i]) qualsum_tab[i] = '0;
        foreach (pos_total[i]) pos_total[i] = '0;
        foreach (pos_qual[i]) pos_qual[i] = '0;
        foreach (kmer_tab[i]) kmer_tab[i] = '0;
        foreach (base_hist[i]) base_hist[i] = '0;
        foreach (med_hist[i]) med_hist[i] = '0;
        foreach (read_hist[i]) read_hist[i] = '0;
        window = '0;
        run_len = '0;
        reads = '0;
        len_sum = '0;
        ovf = 1'b0;
    end

    assign pending = expected_words.size();

    always @(posedge clk)
    begin
        srse_pkg::out_word_t want;
        srse_pkg::out_word_t r;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_index == srse_pkg::CFG_Q20)
                    q20_thr = cfg_data;
                else
                    q30_thr = cfg_data;
            end
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    report("unexpected word", 64'(out_word), '0);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (out_word.result_kind !== want.result_kind)
                        report("result_kind", 64'(out_word.result_kind),
                               64'(want.result_kind));
                    if (out_word.median_quality !== want.median_quality)
                        report("median_quality", 64'(out_word.median_quality),
                               64'(want.median_quality));
                    if (out_word.counter_value !== want.counter_value)
                        report("counter_value", 64'(out_word.counter_value),
                               64'(want.counter_value));
                end
            end
            if (in_valid && in_ready)
            begin
                if (in_word.action == srse_pkg::ACT_READ)
                begin
                    r.result_kind = srse_pkg::KIND_READOUT;
                    r.median_quality = '0;
                    r.counter_value = counter_at(in_word.table_select, in_word.read_index);
                    expected_words.push_back(r);
                end
                else
                begin
                    account_word(in_word);
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: dv/tb_top.sv
// Testbench top for the sequencing read statistics engine: clock, reset,
// stimulus and verdict. Depends on srse_pkg, read_stats_checker and the RTL.
`timescale 1ns / 1ps
`default_nettype none

module tb_top;

    localparam int WATCHDOG_LIMIT = 200000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    srse_pkg::in_word_t  in_word = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    srse_pkg::out_word_t out_word;
    logic                cfg_we = 1'b0;
    logic [0:0]          cfg_index = '0;
    logic [6:0]          cfg_data = '0;
    int                  errors;
    int                  pending;
    int                  idle_cycles = 0;
    logic [7:0]          read_len_left = '0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    sequencing_read_stats_engine dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
        .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    read_stats_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
        .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    // counts cycles with no accepted word, including the post-reset clear
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver: random stalls between words
    initial
    begin
        int gap;
        wait (rst_n);
        forever
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
            repeat (gap) @(negedge clk);
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            @(negedge clk);
            out_ready <= 1'b0;
        end
    end

    task automatic send_word(input srse_pkg::in_word_t w, input logic allow_gap);
        int gap;
        gap = (allow_gap && $urandom_range(0, 3) != 0) ? $urandom_range(0, 19) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [6:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain_and_settle();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    function automatic srse_pkg::in_word_t base_word(input logic [7:0] b,
                                                     input logic [6:0] q,
                                                     input logic last);
        srse_pkg::in_word_t w;
        w = '0;
        w.action = srse_pkg::ACT_BASE;
        w.base_char = b;
        w.qual_char = q;
        w.last_in_read = last;
        w.table_select = 4'($urandom);
        w.read_index = 15'($urandom);
        return w;
    endfunction

    function automatic srse_pkg::in_word_t readout_word(input logic [3:0] sel,
                                                        input logic [14:0] idx);
        srse_pkg::in_word_t w;
        w = '0;
        w.action = srse_pkg::ACT_READ;
        w.base_char = 8'($urandom);
        w.qual_char = 7'($urandom);
        w.last_in_read = 1'($urandom);
        w.table_select = sel;
        w.read_index = idx;
        return w;
    endfunction

    function automatic logic [7:0] pick_letter();
        case ($urandom_range(0, 9))
            0: return "A";
            1: return "C";
            2: return "G";
            3: return "T";
            4: return "U";
            5: return "N";
            6: return 8'($urandom);
            default: return $urandom_range(0, 1) ? "A" : "G";
        endcase
    endfunction

    function automatic logic [14:0] pick_index(input logic [3:0] sel, input logic [11:0] p);
        case ($urandom_range(0, 5))
            0: return 15'($urandom);
            1: return 15'(p);
            2: return {3'($urandom), p};
            default:
            begin
                if (sel <= srse_pkg::TBL_QUALSUM)
                    return {3'($urandom), 12'($urandom_range(0, 40))};
                if (sel == srse_pkg::TBL_KMER)
                    return 15'($urandom_range(0, 1023));
                return 15'($urandom_range(0, 127));
            end
        endcase
    endfunction

    task automatic random_phase(input int count);
        srse_pkg::in_word_t w;
        int len;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                w = readout_word(4'($urandom), 15'($urandom));
                w.read_index = pick_index(w.table_select, 12'($urandom_range(0, 40)));
            end
            else
            begin
                if (read_len_left == 0)
                    read_len_left = 8'($urandom_range(1, 30));
                read_len_left--;
                w = base_word(pick_letter(), 7'($urandom_range(33, 126)),
                              read_len_left == 0);
                if ($urandom_range(0, 50) == 0)
                    w.qual_char = 7'($urandom_range(0, 32));
                if ($urandom_range(0, 60) == 0)
                    w.last_in_read = 1'b1;
                if (w.last_in_read)
                    read_len_left = 0;
            end
            send_word(w, 1'b1);
        end
    endtask

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        // directed: kmer run, lowercase break, extreme qualities, short reads
        send_word(base_word("A", 7'd126, 1'b0), 1'b0);
        send_word(base_word("C", 7'd33, 1'b0), 1'b0);
        send_word(base_word("G", 7'd63, 1'b0), 1'b0);
        send_word(base_word("T", 7'd53, 1'b0), 1'b0);
        send_word(base_word("U", 7'd52, 1'b0), 1'b0);
        send_word(base_word("a", 7'd0, 1'b0), 1'b0);
        send_word(base_word(8'hFF, 7'd127, 1'b1), 1'b0);
        send_word(base_word("G", 7'd40, 1'b1), 1'b0);
        for (int s = 0; s < 13; s++)
            send_word(readout_word(4'(s), 15'(s < 4 ? 0 : 1)), 1'b0);
        send_word(readout_word(srse_pkg::TBL_Q30, 15'h7FFF), 1'b0);
        send_word(readout_word(4'd15, 15'd0), 1'b0);
        drain_and_settle();
        write_reg(srse_pkg::CFG_Q20, 7'd33);
        write_reg(srse_pkg::CFG_Q30, 7'd126);
        random_phase(400);
        drain_and_settle();
        write_reg(srse_pkg::CFG_Q20, 7'd126);
        write_reg(srse_pkg::CFG_Q30, 7'd33);
        random_phase(400);
        send_word(readout_word(srse_pkg::TBL_OVERFLOW, 15'd0), 1'b0);
        drain_and_settle();
        write_reg(srse_pkg::CFG_Q20, 7'($urandom_range(33, 126)));
        write_reg(srse_pkg::CFG_Q30, 7'($urandom_range(33, 126)));
        random_phase(730);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (200) @(negedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
design/srse_pkg.sv
design/srse_ram.sv
design/sequencing_read_stats_engine.sv
dv/read_stats_checker.sv
dv/tb_top.sv
